// ===== sv/iqfd_pkg.sv =====
package iqfd_pkg;

   localparam int WORD_W          = 64;
   localparam int CHAN_W          = 4;
   localparam int CHAN_BYTE_W     = 8;
   localparam int LIMIT_W         = 5;
   localparam int MAX_CHANNELS    = 16;
   localparam int FRAME_WORDS_DEF = 64;

   // Fixed layout of a frame.
   localparam int STAMP_WORD    = 1;
   localparam int CHANNEL_WORD  = 2;
   localparam int PAYLOAD_FIRST = 4;
   localparam int TRAILER_WORDS = 4;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [CHAN_W-1:0] chan_type;

   // Lookup and update of one channel entry, issued on the channel word.
   typedef struct packed {
      logic     wr;
      chan_type idx;
      word_type stamp;
   } table_req_type;

endpackage

// ===== sv/iqfd_chan_table.sv =====
module iqfd_chan_table
   import iqfd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  table_req_type req,
   output logic          new_segment
);

   word_type                  stamp_ff [MAX_CHANNELS];
   logic [MAX_CHANNELS-1:0]   seen_ff;

   // A channel starts a new segment if it was never seen or its stamp moved.
   assign new_segment = !seen_ff[req.idx] || (stamp_ff[req.idx] != req.stamp);

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
      end else if (req.wr) begin
         seen_ff[req.idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (req.wr) begin
         stamp_ff[req.idx] <= req.stamp;
      end
   end

endmodule

// ===== sv/iq_frame_channel_demux.sv =====
// Splits a raw stream of 64-bit words into frames of FRAME_WORDS words and
// emits payload words (frame words 4 through FRAME_WORDS-5) tagged with the
// frame's channel, taken from the low byte of word 2; word 1 is the frame
// timestamp. The first payload word of a frame flags segment_start when its
// channel is new or its timestamp changed. A frame whose channel is at or
// above channel_limit (capped at 16) yields one bad_channel response on its
// channel word and no payload. The block accepts one request per clock while
// req_ready is high, and any response appears from the output register in the
// cycle after acceptance; req_ready drops only while that register holds a response not yet taken.
module iq_frame_channel_demux
   import iqfd_pkg::*;
#(
   parameter int FRAME_WORDS = FRAME_WORDS_DEF
) (
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_ready,
   input  logic [WORD_W-1:0]  req_raw_word,

   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [CHAN_W-1:0]  rsp_out_channel,
   output logic [WORD_W-1:0]  rsp_payload_word,
   output logic               rsp_segment_start,
   output logic               rsp_frame_last,
   output logic               rsp_bad_channel,

   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [LIMIT_W-1:0] csr_channel_limit
);

   localparam int POS_W        = $clog2(FRAME_WORDS);
   localparam int LAST_PAYLOAD = FRAME_WORDS - TRAILER_WORDS - 1;

   logic [POS_W-1:0]   pos_ff, pos_in;
   word_type           frame_stamp_ff, frame_stamp_in;
   chan_type           frame_channel_ff, frame_channel_in;
   logic               frame_accepted_ff, frame_accepted_in;
   logic               frame_new_seg_ff, frame_new_seg_in;
   logic [LIMIT_W-1:0] limit_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   chan_type           rsp_channel_ff, rsp_channel_in;
   word_type           rsp_word_ff, rsp_word_in;
   logic               rsp_seg_ff, rsp_seg_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_bad_ff, rsp_bad_in;

   logic               take;
   logic               emit;
   logic               chan_ok;
   logic               table_new_seg;
   logic [CHAN_BYTE_W-1:0] chan_byte;
   table_req_type      table_req;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign take      = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign chan_byte = req_raw_word[CHAN_BYTE_W-1:0];
   assign chan_ok   = ({1'b0, chan_byte} < (CHAN_BYTE_W+1)'(limit_ff))
                   && ({1'b0, chan_byte} < (CHAN_BYTE_W+1)'(MAX_CHANNELS));

   assign table_req.wr    = take && (pos_ff == POS_W'(CHANNEL_WORD)) && chan_ok;
   assign table_req.idx   = chan_byte[CHAN_W-1:0];
   assign table_req.stamp = frame_stamp_ff;

   iqfd_chan_table u_chan_table (
      .clock       (clock),
      .reset       (reset),
      .req         (table_req),
      .new_segment (table_new_seg)
   );

   always_comb begin
      pos_in            = pos_ff;
      frame_stamp_in    = frame_stamp_ff;
      frame_channel_in  = frame_channel_ff;
      frame_accepted_in = frame_accepted_ff;
      frame_new_seg_in  = frame_new_seg_ff;
      emit              = 1'b0;
      rsp_channel_in    = '0;
      rsp_word_in       = '0;
      rsp_seg_in        = 1'b0;
      rsp_last_in       = 1'b0;
      rsp_bad_in        = 1'b0;

      if (take) begin
         if (pos_ff == POS_W'(FRAME_WORDS - 1)) begin
            pos_in = '0;
         end else begin
            pos_in = pos_ff + POS_W'(1);
         end

         priority if (pos_ff == '0) begin
            frame_accepted_in = 1'b0;
            frame_new_seg_in  = 1'b0;
         end else if (pos_ff == POS_W'(STAMP_WORD)) begin
            frame_stamp_in = req_raw_word;
         end else if (pos_ff == POS_W'(CHANNEL_WORD)) begin
            if (chan_ok) begin
               frame_accepted_in = 1'b1;
               frame_channel_in  = chan_byte[CHAN_W-1:0];
               frame_new_seg_in  = table_new_seg;
            end else begin
               frame_accepted_in = 1'b0;
               frame_new_seg_in  = 1'b0;
               emit              = 1'b1;
               rsp_bad_in        = 1'b1;
            end
         end else if ((pos_ff >= POS_W'(PAYLOAD_FIRST))
                   && ({1'b0, pos_ff} <= (POS_W+1)'(LAST_PAYLOAD))
                   && frame_accepted_ff) begin
            emit           = 1'b1;
            rsp_channel_in = frame_channel_ff;
            rsp_word_in    = req_raw_word;
            rsp_seg_in     = (pos_ff == POS_W'(PAYLOAD_FIRST)) && frame_new_seg_ff;
            rsp_last_in    = ({1'b0, pos_ff} == (POS_W+1)'(LAST_PAYLOAD));
         end else begin
            emit = 1'b0;
         end
      end

      if (take) begin
         rsp_valid_in = emit;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff            <= '0;
         frame_stamp_ff    <= '0;
         frame_channel_ff  <= '0;
         frame_accepted_ff <= 1'b0;
         frame_new_seg_ff  <= 1'b0;
         limit_ff          <= LIMIT_RESET;
         rsp_valid_ff      <= 1'b0;
      end else begin
         pos_ff            <= pos_in;
         frame_stamp_ff    <= frame_stamp_in;
         frame_channel_ff  <= frame_channel_in;
         frame_accepted_ff <= frame_accepted_in;
         frame_new_seg_ff  <= frame_new_seg_in;
         rsp_valid_ff      <= rsp_valid_in;
         if (csr_valid) begin
            limit_ff <= csr_channel_limit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take && emit) begin
         rsp_channel_ff <= rsp_channel_in;
         rsp_word_ff    <= rsp_word_in;
         rsp_seg_ff     <= rsp_seg_in;
         rsp_last_ff    <= rsp_last_in;
         rsp_bad_ff     <= rsp_bad_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_channel   = rsp_channel_ff;
   assign rsp_payload_word  = rsp_word_ff;
   assign rsp_segment_start = rsp_seg_ff;
   assign rsp_frame_last    = rsp_last_ff;
   assign rsp_bad_channel   = rsp_bad_ff;

endmodule

// ===== bench/iqfd_checker.sv =====
module iqfd_checker
   import iqfd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [WORD_W-1:0]  req_raw_word,

   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [CHAN_W-1:0]  rsp_out_channel,
   input  logic [WORD_W-1:0]  rsp_payload_word,
   input  logic               rsp_segment_start,
   input  logic               rsp_frame_last,
   input  logic               rsp_bad_channel,

   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [LIMIT_W-1:0] csr_channel_limit,

   output int                 fail_count,
   output int                 pending
);

   localparam int LAST_PAYLOAD = FRAME_WORDS_DEF - TRAILER_WORDS - 1;

   typedef struct packed {
      chan_type chan;
      word_type payload;
      logic     seg;
      logic     last;
      logic     bad;
   } tagged_word_type;

   tagged_word_type tagged_q[$];

   logic [LIMIT_W-1:0] limit;
   int unsigned        pos;
   word_type           stamp;
   chan_type           chan;
   logic               accepted;
   logic               new_seg;
   word_type           last_stamp [MAX_CHANNELS];
   logic               seen       [MAX_CHANNELS];

   // Follows one raw word through the frame and queues the tagged word it yields.
   task automatic demux_word(input word_type w);
      int unsigned            cap;
      logic [CHAN_BYTE_W-1:0] ch;
      tagged_word_type        t;
      cap = (limit > MAX_CHANNELS) ? MAX_CHANNELS : limit;
      ch  = w[CHAN_BYTE_W-1:0];
      t   = '0;
      if (pos == 0) begin
         accepted = 1'b0;
         new_seg  = 1'b0;
      end else if (pos == STAMP_WORD) begin
         stamp = w;
      end else if (pos == CHANNEL_WORD) begin
         if (ch < cap) begin
            accepted         = 1'b1;
            chan             = ch[CHAN_W-1:0];
            new_seg          = !seen[chan] || (last_stamp[chan] != stamp);
            last_stamp[chan] = stamp;
            seen[chan]       = 1'b1;
         end else begin
            accepted = 1'b0;
            new_seg  = 1'b0;
            t.bad    = 1'b1;
            tagged_q.push_back(t);
         end
      end else if (pos >= PAYLOAD_FIRST && pos <= LAST_PAYLOAD && accepted) begin
         t.chan    = chan;
         t.payload = w;
         t.seg     = (pos == PAYLOAD_FIRST) && new_seg;
         t.last    = (pos == LAST_PAYLOAD);
         tagged_q.push_back(t);
      end
      pos = (pos + 1) % FRAME_WORDS_DEF;
   endtask

   always @(posedge clock) begin
      tagged_word_type got;
      tagged_word_type want;
      if (reset) begin
         tagged_q.delete();
         limit      = LIMIT_RESET;
         pos        = 0;
         stamp      = '0;
         chan       = '0;
         accepted   = 1'b0;
         new_seg    = 1'b0;
         fail_count = 0;
         for (int i = 0; i < MAX_CHANNELS; i++) begin
            last_stamp[i] = '0;
            seen[i]       = 1'b0;
         end
      end else begin
         // A request at the same edge as a register write still sees the old limit.
         if (req_valid && req_ready)
            demux_word(req_raw_word);
         if (csr_valid && csr_ready)
            limit = csr_channel_limit;
         if (rsp_valid && rsp_ready) begin
            got = {rsp_out_channel, rsp_payload_word, rsp_segment_start,
                   rsp_frame_last, rsp_bad_channel};
            if (tagged_q.size() == 0) begin
               $display("%0t: unexpected response ch=%0d word=%h seg=%0b last=%0b bad=%0b",
                        $time, got.chan, got.payload, got.seg, got.last, got.bad);
               fail_count++;
            end else begin
               want = tagged_q.pop_front();
               if (got !== want) begin
                  $display("%0t: expected ch=%0d word=%h seg=%0b last=%0b bad=%0b",
                           $time, want.chan, want.payload, want.seg, want.last, want.bad);
                  $display("%0t:   actual ch=%0d word=%h seg=%0b last=%0b bad=%0b",
                           $time, got.chan, got.payload, got.seg, got.last, got.bad);
                  fail_count++;
               end
            end
         end
      end
      pending = tagged_q.size();
   end

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
   import iqfd_pkg::*;

   typedef enum int { FILL_RANDOM, FILL_ZERO, FILL_ONES } fill_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   word_type           req_raw_word;
   logic               rsp_valid;
   logic               rsp_ready = 1'b1;
   chan_type           rsp_out_channel;
   word_type           rsp_payload_word;
   logic               rsp_segment_start;
   logic               rsp_frame_last;
   logic               rsp_bad_channel;
   logic               csr_valid;
   logic               csr_ready;
   logic [LIMIT_W-1:0] csr_channel_limit;

   int                 fail_count;
   int                 pending;
   logic               idle_send;
   logic               stall_recv = 1'b0;
   int                 stall_left = 0;
   logic [LIMIT_W-1:0] cur_limit;
   word_type           stamp_pool [4];

   iq_frame_channel_demux dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_raw_word      (req_raw_word),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_channel   (rsp_out_channel),
      .rsp_payload_word  (rsp_payload_word),
      .rsp_segment_start (rsp_segment_start),
      .rsp_frame_last    (rsp_frame_last),
      .rsp_bad_channel   (rsp_bad_channel),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_channel_limit (csr_channel_limit)
   );

   iqfd_checker watch (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_raw_word      (req_raw_word),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_channel   (rsp_out_channel),
      .rsp_payload_word  (rsp_payload_word),
      .rsp_segment_start (rsp_segment_start),
      .rsp_frame_last    (rsp_frame_last),
      .rsp_bad_channel   (rsp_bad_channel),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_channel_limit (csr_channel_limit),
      .fail_count        (fail_count),
      .pending           (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("tb_top NOT OK");
      $finish;
   end

   // The receiver stalls in random bursts while stall_recv is set.
   always @(negedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else if (stall_recv && $urandom_range(0, 4) == 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= $urandom_range(0, 6);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_word(input word_type w);
      @(negedge clock);
      if (idle_send && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_raw_word <= w;
      do @(posedge clock); while (req_ready !== 1'b1);
   endtask

   // Stops sending and waits until every expected response has come back.
   task automatic drain_requests();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_limit(input logic [LIMIT_W-1:0] value);
      drain_requests();
      csr_valid         <= 1'b1;
      csr_channel_limit <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      @(negedge clock);
      csr_valid <= 1'b0;
      cur_limit = value;
   endtask

   task automatic send_frame(input word_type stamp, input logic [CHAN_BYTE_W-1:0] chan_byte,
                             input fill_type fill, input int pause_at);
      word_type w;
      for (int i = 0; i < FRAME_WORDS_DEF; i++) begin
         w = {$urandom, $urandom};
         if (i == STAMP_WORD)
            w = stamp;
         else if (i == CHANNEL_WORD)
            w[CHAN_BYTE_W-1:0] = chan_byte;
         else if (i >= PAYLOAD_FIRST && i < FRAME_WORDS_DEF - TRAILER_WORDS) begin
            if (fill == FILL_ZERO)
               w = '0;
            else if (fill == FILL_ONES)
               w = '1;
         end
         send_word(w);
         if (i == pause_at)
            drain_requests();
      end
   endtask

   task automatic random_frame(input int pause_at);
      int                     cap;
      int                     pick;
      logic [CHAN_BYTE_W-1:0] ch;
      word_type               stamp;
      cap  = (cur_limit > MAX_CHANNELS) ? MAX_CHANNELS : cur_limit;
      pick = $urandom_range(0, 9);
      if (cap != 0 && pick < 7)
         ch = CHAN_BYTE_W'($urandom_range(0, cap - 1));
      else if (pick < 9)
         ch = CHAN_BYTE_W'(cap + $urandom_range(0, 15));
      else
         ch = CHAN_BYTE_W'($urandom_range(0, 255));
      // A small pool of timestamps makes repeated stamps on a channel common.
      if ($urandom_range(0, 3) == 0)
         stamp = {$urandom, $urandom};
      else
         stamp = stamp_pool[2'($urandom_range(0, 3))];
      send_frame(stamp, ch, FILL_RANDOM, pause_at);
   endtask

   initial begin
      logic [LIMIT_W-1:0] phase_limit [5];
      int                 phase_frames [5];
      logic               first_random;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_raw_word      = '0;
      csr_valid         = 1'b0;
      csr_channel_limit = '0;
      idle_send         = 1'b1;
      cur_limit         = LIMIT_RESET;
      stamp_pool[0]     = '0;
      for (int i = 1; i < 4; i++)
         stamp_pool[i] = {$urandom, $urandom};
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      stall_recv = 1'b1;

      // A new channel starts a segment; the same stamp again does not.
      send_frame('0, 8'd0, FILL_ONES, -1);
      send_frame('0, 8'd0, FILL_ZERO, -1);
      send_frame('1, 8'd15, FILL_RANDOM, -1);
      send_frame('1, 8'd16, FILL_RANDOM, -1);
      send_frame(stamp_pool[1], 8'hFF, FILL_RANDOM, -1);
      // With a limit of zero every frame is dropped.
      write_limit('0);
      send_frame(stamp_pool[1], 8'd0, FILL_RANDOM, -1);
      // A limit above the table size acts as the table size.
      write_limit('1);
      send_frame(stamp_pool[2], 8'd15, FILL_RANDOM, -1);
      send_frame(stamp_pool[2], 8'd16, FILL_RANDOM, -1);
      write_limit(LIMIT_W'(1));
      send_frame(stamp_pool[3], 8'd1, FILL_RANDOM, -1);
      send_frame(stamp_pool[3], 8'd0, FILL_RANDOM, -1);

      phase_limit[0] = LIMIT_W'($urandom_range(1, 16));
      phase_limit[1] = LIMIT_W'(16);
      phase_limit[2] = LIMIT_W'($urandom_range(0, 31));
      phase_limit[3] = LIMIT_W'(1);
      phase_limit[4] = LIMIT_W'(16);
      phase_frames   = '{5, 5, 4, 4, 4};
      first_random   = 1'b1;
      for (int p = 0; p < 5; p++) begin
         write_limit(phase_limit[p]);
         for (int f = 0; f < phase_frames[p]; f++) begin
            idle_send  = (p != 4) && ($urandom_range(0, 3) != 0);
            stall_recv = (p != 4) && ($urandom_range(0, 3) != 0);
            if (first_random || $urandom_range(0, 5) == 0)
               random_frame($urandom_range(0, FRAME_WORDS_DEF - 1));
            else
               random_frame(-1);
            first_random = 1'b0;
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (fail_count == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

endmodule
